/* rtl/tdpt_pkg.sv */
// Shared types for the trial-division prime test: controller states and command/status bundles.
`timescale 1ns / 1ps

package tdpt_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_CHECK,
        ST_FINISH
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // capture candidate, start first division with divisor 3
        logic step;        // one restoring-division step
        logic next_div;    // advance divisor by two, restart division
        logic set_verdict; // latch verdict from the current check
        logic verdict;
        logic publish;     // move verdict into the output register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic trivial;   // candidate settled without division (two, below two, or even)
        logic div_last;  // current step is the last of this division
        logic bound_hit; // divisor exceeds quotient: divisor squared exceeds value
        logic rem_zero;  // remainder of the finished division is zero
    } t_dp_sts;

endpackage

/* rtl/trial_division_prime_test_unit.sv */
// Top level of the trial-division prime test: controller plus divider datapath.
// Two, values below two and even values are settled without division; otherwise
//   odd divisors are tried in turn (3, 5, ... up to sqrt).
// Each divisor costs VALUE_BITS restoring-division steps followed by a check;
//   worst case at VALUE_BITS = 31 is about 23170 divisors.
// One transaction in flight; a new one is taken once the verdict is in the output register.
// Reset (synchronous, active low) clears controller state and the output valid.
`timescale 1ns / 1ps

module trial_division_prime_test_unit #(
    parameter int VALUE_BITS = 31
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input transaction
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [VALUE_BITS-1:0] i_candidate,
    // result transaction
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic                  o_is_prime
);

    // Command and status bundles between the controller and the datapath.
    tdpt_pkg::t_dp_cmd cmd;
    tdpt_pkg::t_dp_sts sts;

    // Controller: idle, divide, check, finish. Hold the verdict until the
    // output register is free, then publish it and drop back to idle.
    tdpt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // Datapath: the quotient register doubles as the dividend shift register,
    // so one pass yields both the bound test (divisor > quotient) and the
    // remainder test.
    tdpt_dp #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_candidate (i_candidate),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_is_prime  (o_is_prime)
    );

    // An accepted transaction keeps the input side stalled in the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input not stalled after accepting a transaction");

    // Only one datapath command kind is issued per cycle.
    a_one_command: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({cmd.load, cmd.step, cmd.next_div, cmd.publish}) <= 1)
        else $error("conflicting datapath commands");

    // A published verdict shows up as a valid result in the next cycle.
    a_publish_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.publish |=> o_valid)
        else $error("published verdict not presented");

    // Never publish over a result that is still stalled at the output.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.publish |-> (!o_valid || !i_stall))
        else $error("output register overwritten while stalled");

endmodule

/* rtl/tdpt_dp.sv */
// Datapath: candidate, trial divisor and a bit-serial restoring divider.
`timescale 1ns / 1ps

module tdpt_dp #(
    parameter int VALUE_BITS = 31
) (
    input  logic                    i_clk,
    input  logic [VALUE_BITS-1:0]   i_candidate,
    input  tdpt_pkg::t_dp_cmd       i_cmd,
    output tdpt_pkg::t_dp_sts       o_sts,
    output logic                    o_is_prime
);

    localparam int CNT_W = $clog2(VALUE_BITS);

    logic [VALUE_BITS-1:0] r_value;
    logic [VALUE_BITS-1:0] r_div;
    logic [VALUE_BITS-1:0] r_quo;   // dividend shifts out, quotient shifts in
    logic [VALUE_BITS-1:0] r_rem;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_verdict;
    logic                  r_is_prime;

    logic [VALUE_BITS:0]   rem_sh;
    logic [VALUE_BITS:0]   diff;
    logic                  q_bit;
    logic                  cand_two;

    assign rem_sh = {r_rem, r_quo[VALUE_BITS-1]};
    assign diff   = rem_sh - {1'b0, r_div};
    assign q_bit  = (rem_sh >= {1'b0, r_div});

    assign cand_two = (i_candidate == VALUE_BITS'(2));

    assign o_sts.trivial   = cand_two || (i_candidate < VALUE_BITS'(2)) || !i_candidate[0];
    assign o_sts.div_last  = (r_cnt == '0);
    assign o_sts.bound_hit = (r_div > r_quo);
    assign o_sts.rem_zero  = (r_rem == '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_value   <= i_candidate;
            r_div     <= VALUE_BITS'(3);
            r_quo     <= i_candidate;
            r_rem     <= '0;
            r_cnt     <= CNT_W'(VALUE_BITS - 1);
            r_verdict <= cand_two;
        end else if (i_cmd.step) begin
            r_quo <= {r_quo[VALUE_BITS-2:0], q_bit};
            r_rem <= q_bit ? diff[VALUE_BITS-1:0] : rem_sh[VALUE_BITS-1:0];
            r_cnt <= r_cnt - CNT_W'(1);
        end else if (i_cmd.next_div) begin
            r_div <= r_div + VALUE_BITS'(2);
            r_quo <= r_value;
            r_rem <= '0;
            r_cnt <= CNT_W'(VALUE_BITS - 1);
        end
        if (i_cmd.set_verdict) begin
            r_verdict <= i_cmd.verdict;
        end
        if (i_cmd.publish) begin
            r_is_prime <= r_verdict;
        end
    end

    assign o_is_prime = r_is_prime;

endmodule

/* rtl/tdpt_ctrl.sv */
// Controller: sequences trial divisions and manages the output register handshake.
`timescale 1ns / 1ps

module tdpt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    output logic              o_valid,
    input  logic              i_stall,
    input  tdpt_pkg::t_dp_sts i_sts,
    output tdpt_pkg::t_dp_cmd o_cmd
);

    tdpt_pkg::t_state r_state;
    tdpt_pkg::t_state n_state;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             out_free;
    logic             accept;
    logic             settled;

    assign out_free = !r_out_valid || !i_stall;
    assign accept   = i_valid && (r_state == tdpt_pkg::ST_IDLE);
    assign settled  = i_sts.bound_hit || i_sts.rem_zero;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tdpt_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_state = i_sts.trivial ? tdpt_pkg::ST_FINISH : tdpt_pkg::ST_DIV;
                end
            end
            tdpt_pkg::ST_DIV: begin
                if (i_sts.div_last) begin
                    n_state = tdpt_pkg::ST_CHECK;
                end
            end
            tdpt_pkg::ST_CHECK: begin
                n_state = settled ? tdpt_pkg::ST_FINISH : tdpt_pkg::ST_DIV;
            end
            tdpt_pkg::ST_FINISH: begin
                if (out_free) begin
                    n_state = tdpt_pkg::ST_IDLE;
                end
            end
            default: n_state = tdpt_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            tdpt_pkg::ST_IDLE: begin
                o_cmd.load = accept;
            end
            tdpt_pkg::ST_DIV: begin
                o_cmd.step = 1'b1;
            end
            tdpt_pkg::ST_CHECK: begin
                o_cmd.next_div    = !settled;
                o_cmd.set_verdict = settled;
                o_cmd.verdict     = i_sts.bound_hit;
            end
            tdpt_pkg::ST_FINISH: begin
                o_cmd.publish = out_free;
            end
            default: o_cmd = '0;
        endcase
    end

    always_comb begin
        if (o_cmd.publish) begin
            n_out_valid = 1'b1;
        end else begin
            n_out_valid = r_out_valid && i_stall;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tdpt_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall = (r_state != tdpt_pkg::ST_IDLE);
    assign o_valid = r_out_valid;

endmodule
